[sv/canrx_pkg.sv]
`timescale 1ns / 1ps

package canrx_pkg;

  // Field widths of one frame
  localparam int unsigned IDENT_W   = 32;
  localparam int unsigned LENGTH_W  = 4;
  localparam int unsigned PAYLOAD_W = 32;
  localparam int unsigned FILL_W    = 5;
  localparam int unsigned COUNTER_W = 32;

  // Largest legal data length code
  localparam logic [LENGTH_W-1:0] MAX_LENGTH = LENGTH_W'(8);

  // Default frame FIFO depth
  localparam int unsigned FIFO_DEPTH_DEF = 16;

  // Item kinds on the input channel
  localparam logic KIND_MAILBOX = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  // Frame as held in the FIFO
  typedef struct packed {
    logic [IDENT_W-1:0]   ident;
    logic [LENGTH_W-1:0]  length;
    logic                 extended;
    logic [PAYLOAD_W-1:0] payload_low;
    logic [PAYLOAD_W-1:0] payload_high;
  } frame_t;

  localparam int unsigned FRAME_W = $bits(frame_t);

  // Classified command handed from the front end to the back end
  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_DROP,
    CMD_LEN_ERR
  } cmd_t;

  typedef struct packed {
    cmd_t   cmd;
    frame_t frame;
  } cmd_entry_t;

  // Back end sequencer states
  typedef enum logic {
    BK_IDLE,
    BK_READ
  } back_state_t;

  // Back end status seen by the top level
  typedef struct packed {
    logic reading;
    logic empty;
    logic full;
  } back_stat_t;

endpackage

[sv/canrx_item_if.sv]
`timescale 1ns / 1ps

interface canrx_item_if;
  import canrx_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic                 overwritten;
  logic [IDENT_W-1:0]   frame_ident;
  logic [LENGTH_W-1:0]  length_code;
  logic                 extended_flag;
  logic [PAYLOAD_W-1:0] payload_low;
  logic [PAYLOAD_W-1:0] payload_high;

  modport source (
    output valid, kind, overwritten, frame_ident, length_code, extended_flag,
           payload_low, payload_high,
    input  ready
  );

  modport sink (
    input  valid, kind, overwritten, frame_ident, length_code, extended_flag,
           payload_low, payload_high,
    output ready
  );

endinterface

[sv/canrx_result_if.sv]
`timescale 1ns / 1ps

interface canrx_result_if;
  import canrx_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 frame_valid;
  logic [IDENT_W-1:0]   out_ident;
  logic [LENGTH_W-1:0]  out_length;
  logic                 out_extended;
  logic [PAYLOAD_W-1:0] out_payload_low;
  logic [PAYLOAD_W-1:0] out_payload_high;
  logic [FILL_W-1:0]    fill_level;
  logic [COUNTER_W-1:0] accepted_total;
  logic [COUNTER_W-1:0] discarded_total;
  logic [COUNTER_W-1:0] error_total;

  modport source (
    output valid, frame_valid, out_ident, out_length, out_extended, out_payload_low,
           out_payload_high, fill_level, accepted_total, discarded_total, error_total,
    input  ready
  );

  modport sink (
    input  valid, frame_valid, out_ident, out_length, out_extended, out_payload_low,
           out_payload_high, fill_level, accepted_total, discarded_total, error_total,
    output ready
  );

endinterface

[sv/canrx_ram.sv]
`timescale 1ns / 1ps

module canrx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/canrx_front.sv]
`timescale 1ns / 1ps

module canrx_front (
  input  logic                   clk,
  input  logic                   rst,
  canrx_item_if.sink             item,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output canrx_pkg::cmd_entry_t  dn_entry
);
  import canrx_pkg::*;

  logic       stage_valid;
  cmd_entry_t stage_entry;
  cmd_entry_t entry_next;
  logic       take;

  // Take a new beat whenever the stage is empty or drains this cycle
  assign item.ready = !stage_valid || dn_ready;
  assign take       = item.valid && item.ready;

  // Classify the item: overwrite beats a bad length
  always_comb begin
    entry_next.frame.ident        = item.frame_ident;
    entry_next.frame.length       = item.length_code;
    entry_next.frame.extended     = item.extended_flag;
    entry_next.frame.payload_low  = item.payload_low;
    entry_next.frame.payload_high = item.payload_high;
    priority if (item.kind == KIND_READ) begin
      entry_next.cmd = CMD_POP;
    end else if (item.overwritten) begin
      entry_next.cmd = CMD_DROP;
    end else if (item.length_code > MAX_LENGTH) begin
      entry_next.cmd = CMD_LEN_ERR;
    end else begin
      entry_next.cmd = CMD_PUSH;
    end
  end

  // Hold stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take) begin
      stage_valid <= 1'b1;
    end else if (dn_ready) begin
      stage_valid <= 1'b0;
    end
  end

  // Capture the classified beat
  always_ff @(posedge clk) begin
    if (take) begin
      stage_entry <= entry_next;
    end
  end

  assign dn_valid = stage_valid;
  assign dn_entry = stage_entry;

endmodule

[sv/canrx_cmdq.sv]
`timescale 1ns / 1ps

module canrx_cmdq (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  canrx_pkg::cmd_entry_t  up_entry,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output canrx_pkg::cmd_entry_t  dn_entry
);
  import canrx_pkg::*;

  cmd_entry_t  slots [2];
  logic        wr_idx;
  logic        rd_idx;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign up_ready = (count != 2'd2);
  assign dn_valid = (count != 2'd0);
  assign dn_entry = slots[rd_idx];
  assign push     = up_valid && up_ready;
  assign pop      = dn_valid && dn_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= 1'b0;
      rd_idx <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_idx <= !wr_idx;
      end
      if (pop) begin
        rd_idx <= !rd_idx;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Store incoming commands
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_idx] <= up_entry;
    end
  end

endmodule

[sv/canrx_back.sv]
`timescale 1ns / 1ps

module canrx_back #(
  parameter int unsigned DEPTH = canrx_pkg::FIFO_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  canrx_pkg::cmd_entry_t  q_entry,
  canrx_result_if.source         result,
  output canrx_pkg::back_stat_t  stat
);
  import canrx_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  back_state_t          state, state_next;
  logic [CW-1:0]        count, count_next;
  logic [AW-1:0]        rd_ptr, rd_ptr_next;
  logic [AW-1:0]        wr_ptr, wr_ptr_next;
  logic [COUNTER_W-1:0] acc_cnt, acc_cnt_next;
  logic [COUNTER_W-1:0] dis_cnt, dis_cnt_next;
  logic [COUNTER_W-1:0] err_cnt, err_cnt_next;
  logic                 out_valid, out_valid_next;
  logic                 out_frame_valid;
  frame_t               out_frame;

  logic                 can_go;
  logic                 load;
  logic                 ld_frame_valid;
  frame_t               ld_frame;
  logic                 ram_we;
  logic                 ram_re;
  logic [FRAME_W-1:0]   ram_rdata;
  frame_t               rd_frame;

  canrx_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (q_entry.frame),
    .re    (ram_re),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  assign rd_frame = frame_t'(ram_rdata);

  // Execute one command when the result register is free or drains now
  assign can_go = q_valid && (!out_valid || result.ready);

  always_comb begin
    state_next     = state;
    count_next     = count;
    rd_ptr_next    = rd_ptr;
    wr_ptr_next    = wr_ptr;
    acc_cnt_next   = acc_cnt;
    dis_cnt_next   = dis_cnt;
    err_cnt_next   = err_cnt;
    q_ready        = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    load           = 1'b0;
    ld_frame_valid = 1'b0;
    ld_frame       = '0;
    unique case (state)
      BK_IDLE: begin
        if (can_go) begin
          q_ready = 1'b1;
          unique case (q_entry.cmd)
            CMD_PUSH: begin
              load         = 1'b1;
              acc_cnt_next = acc_cnt + COUNTER_W'(1);
              if (count == FULL_COUNT) begin
                dis_cnt_next = dis_cnt + COUNTER_W'(1);
              end else begin
                ram_we      = 1'b1;
                wr_ptr_next = (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + AW'(1);
                count_next  = count + CW'(1);
              end
            end
            CMD_POP: begin
              if (count == '0) begin
                load = 1'b1;
              end else begin
                ram_re     = 1'b1;
                state_next = BK_READ;
              end
            end
            CMD_DROP: begin
              load         = 1'b1;
              dis_cnt_next = dis_cnt + COUNTER_W'(1);
            end
            CMD_LEN_ERR: begin
              load         = 1'b1;
              err_cnt_next = err_cnt + COUNTER_W'(1);
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      BK_READ: begin
        // Result register is always empty here
        load           = 1'b1;
        ld_frame_valid = 1'b1;
        ld_frame       = rd_frame;
        rd_ptr_next    = (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + AW'(1);
        count_next     = count - CW'(1);
        state_next     = BK_IDLE;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
    out_valid_next = load || (out_valid && !result.ready);
  end

  // Hold control state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      count     <= '0;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      acc_cnt   <= '0;
      dis_cnt   <= '0;
      err_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rd_ptr    <= rd_ptr_next;
      wr_ptr    <= wr_ptr_next;
      acc_cnt   <= acc_cnt_next;
      dis_cnt   <= dis_cnt_next;
      err_cnt   <= err_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_frame_valid <= ld_frame_valid;
      out_frame       <= ld_frame;
    end
  end

  // Counters and fill only change when a new result is loaded
  assign result.valid            = out_valid;
  assign result.frame_valid      = out_frame_valid;
  assign result.out_ident        = out_frame.ident;
  assign result.out_length       = out_frame.length;
  assign result.out_extended     = out_frame.extended;
  assign result.out_payload_low  = out_frame.payload_low;
  assign result.out_payload_high = out_frame.payload_high;
  assign result.fill_level       = FILL_W'(count);
  assign result.accepted_total   = acc_cnt;
  assign result.discarded_total  = dis_cnt;
  assign result.error_total      = err_cnt;

  assign stat.reading = (state == BK_READ);
  assign stat.empty   = (count == '0);
  assign stat.full    = (count == FULL_COUNT);

endmodule

[sv/can_receive_frame_fifo.sv]
`timescale 1ns / 1ps

// Channel   Dir   Beat contents
// item      in    kind, overwritten, frame_ident, length_code, extended_flag, payload
// result    out   frame_valid, frame fields, fill_level, three wrapping counters
//
// A beat passes a classify register and a two-entry command queue before the
// back end, which gives one result per beat. A read of a held frame also passes
// the registered read port of the frame store, and the back end takes no new
// command until that frame is in the result register. Reset (rst, synchronous)
// empties the FIFO and clears all counters; the frame store itself is not
// cleared. A stalled result holds the back end; the front keeps taking beats
// until the command queue and the classify register are full.

module can_receive_frame_fifo #(
  parameter int unsigned FIFO_DEPTH = canrx_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  canrx_item_if.sink      item,
  canrx_result_if.source  result
);
  import canrx_pkg::*;

  logic       fr_valid;
  logic       fr_ready;
  cmd_entry_t fr_entry;
  logic       q_valid;
  logic       q_ready;
  cmd_entry_t q_entry;
  back_stat_t stat;

  canrx_front u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .dn_valid (fr_valid),
    .dn_ready (fr_ready),
    .dn_entry (fr_entry)
  );

  canrx_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .up_valid (fr_valid),
    .up_ready (fr_ready),
    .up_entry (fr_entry),
    .dn_valid (q_valid),
    .dn_ready (q_ready),
    .dn_entry (q_entry)
  );

  canrx_back #(
    .DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_entry (q_entry),
    .result  (result),
    .stat    (stat)
  );

  // A frame read always lands in the result register on the next edge
  assert property (@(posedge clk) disable iff (rst)
    stat.reading |=> (result.valid && result.frame_valid))
    else $error("frame read did not produce a frame result");

  // A read of an empty FIFO yields an empty result
  assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready && (q_entry.cmd == CMD_POP) && stat.empty)
      |=> (result.valid && !result.frame_valid))
    else $error("read of empty FIFO returned a frame");

  // A result without a frame carries zero frame fields
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.frame_valid)
      |-> (result.out_ident == '0 && result.out_length == '0 && !result.out_extended
           && result.out_payload_low == '0 && result.out_payload_high == '0))
    else $error("frame fields not zero on a frameless result");

  // A push into a full FIFO is dropped and leaves it full
  assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready && (q_entry.cmd == CMD_PUSH) && stat.full) |=> stat.full)
    else $error("push into a full FIFO changed its fill");

endmodule
